/* hdl/assert_macros.svh */
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ACFSL_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("same-cycle implication failed");

`define ACFSL_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

/* hdl/acfsl_pkg.sv */
package acfsl_pkg;

    localparam logic [2:0] OP_SET_G = 3'd0;
    localparam logic [2:0] OP_SET_C = 3'd1;
    localparam logic [2:0] OP_GET_G = 3'd2;
    localparam logic [2:0] OP_GET_C = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    localparam int          G_FIELDS  = 13;
    localparam int          C_FIELDS  = 4;
    localparam int          GW        = 29;
    localparam int          CW        = 9;
    localparam int          CH_PER    = 32;
    localparam int          GLOB_BITS = 49;
    localparam int          CH_BITS   = 12;
    localparam int          TAIL_W    = 15;
    localparam int          STREAM_W  = 448;
    localparam logic [3:0]  LAST_WORD = 4'd13;
    localparam logic [11:0] ALL_CH    = 12'hFFF;
    localparam logic [31:0] CTRL_RST  = 32'd4;
    localparam logic [31:0] CTRL_SHF  = 32'd2;
    localparam logic [31:0] CTRL_SEL  = 32'h0001_0000;

    typedef enum logic [3:0] {
        RS_STATUS, RS_GGET, RS_CGET, RS_C4, RS_C0, RS_WORD, RS_C2, RS_CSEL, RS_END
    } t_rsel;

    typedef struct packed {
        logic [2:0]  operation;
        logic [11:0] chip_set;
        logic [3:0]  chip;
        logic [11:0] channel;
        logic [3:0]  fld_idx;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic        write_target;
        logic [31:0] data;
        logic        ok;
        logic        last;
    } t_res;

    typedef struct packed {
        logic  latch;
        logic  clr;
        logic  glob_wr;
        logic  rd;
        logic  wr;
        logic  addr_zero;
        logic  addr_chan;
        logic  addr_top;
        logic  addr_inc;
        logic  addr_dec;
        logic  pack_init;
        logic  pack_shift;
        logic  pack_tail;
        logic  word_shift;
        logic  emit;
        t_rsel rsel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       fail;
        logic       all;
        logic       end_up;
        logic       end_dn;
    } t_sts;

    function automatic logic [4:0] g_off(input logic [3:0] fid);
        case (fid)
            4'd0:    g_off = 5'd0;
            4'd1:    g_off = 5'd2;
            4'd2:    g_off = 5'd4;
            4'd3:    g_off = 5'd5;
            4'd4:    g_off = 5'd6;
            4'd5:    g_off = 5'd7;
            4'd6:    g_off = 5'd8;
            4'd7:    g_off = 5'd9;
            4'd8:    g_off = 5'd11;
            4'd9:    g_off = 5'd12;
            4'd10:   g_off = 5'd22;
            4'd11:   g_off = 5'd27;
            4'd12:   g_off = 5'd28;
            default: g_off = 5'd0;
        endcase
    endfunction

    function automatic logic [GW-1:0] g_mask(input logic [3:0] fid);
        case (fid)
            4'd0:    g_mask = 29'h0000_0003;
            4'd1:    g_mask = 29'h0000_000C;
            4'd2:    g_mask = 29'h0000_0010;
            4'd3:    g_mask = 29'h0000_0020;
            4'd4:    g_mask = 29'h0000_0040;
            4'd5:    g_mask = 29'h0000_0080;
            4'd6:    g_mask = 29'h0000_0100;
            4'd7:    g_mask = 29'h0000_0600;
            4'd8:    g_mask = 29'h0000_0800;
            4'd9:    g_mask = 29'h003F_F000;
            4'd10:   g_mask = 29'h07C0_0000;
            4'd11:   g_mask = 29'h0800_0000;
            4'd12:   g_mask = 29'h1000_0000;
            default: g_mask = 29'h0;
        endcase
    endfunction

    function automatic logic [2:0] c_off(input logic [1:0] fid);
        case (fid)
            2'd0:    c_off = 3'd0;
            2'd1:    c_off = 3'd1;
            2'd2:    c_off = 3'd2;
            default: c_off = 3'd5;
        endcase
    endfunction

    function automatic logic [CW-1:0] c_mask(input logic [1:0] fid);
        case (fid)
            2'd0:    c_mask = 9'h001;
            2'd1:    c_mask = 9'h002;
            2'd2:    c_mask = 9'h01C;
            default: c_mask = 9'h1E0;
        endcase
    endfunction

endpackage

/* hdl/acfsl_in_if.sv */
interface acfsl_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [11:0] chip_set;
    logic [3:0]  chip;
    logic [11:0] channel;
    logic [3:0]  fld_idx;
    logic [31:0] value;

    modport source (output valid, operation, chip_set, chip, channel, fld_idx, value,
                    input ready);
    modport sink (input valid, operation, chip_set, chip, channel, fld_idx, value,
                  output ready);
endinterface

/* hdl/acfsl_out_if.sv */
interface acfsl_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        write_target;
    logic [31:0] data;
    logic        ok;
    logic        last;

    modport source (output valid, kind, write_target, data, ok, last, input ready);
    modport sink (input valid, kind, write_target, data, ok, last, output ready);
endinterface

/* hdl/acfsl_datapath.sv */
module acfsl_datapath #(
    parameter int NUM_CHIPS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acfsl_pkg::t_item   i_item,
    input  acfsl_pkg::t_cmd    i_cmd,
    output acfsl_pkg::t_sts    o_sts,
    output acfsl_pkg::t_res    o_res
);
    localparam int NUM_CH = NUM_CHIPS * acfsl_pkg::CH_PER;
    localparam int CH_W   = $clog2(NUM_CH);
    localparam int CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
    localparam int SW     = acfsl_pkg::STREAM_W;

    acfsl_pkg::t_item             r_item;
    logic [acfsl_pkg::GW-1:0]     r_glob [NUM_CHIPS];
    logic [acfsl_pkg::CW-1:0]     mem [NUM_CH];
    logic [acfsl_pkg::CW-1:0]     r_rdata;
    logic [CH_W-1:0]              r_addr;
    logic [CH_W-1:0]              n_addr;
    logic [SW-1:0]                r_stream;
    logic [SW-1:0]                n_stream;

    logic [acfsl_pkg::GW-1:0]     w_g;
    logic [acfsl_pkg::GW-1:0]     w_gm;
    logic [4:0]                   w_goff;
    logic [acfsl_pkg::CW-1:0]     w_cm;
    logic [2:0]                   w_coff;
    logic [31:0]                  w_cv;
    logic [acfsl_pkg::CW-1:0]     w_merged;
    logic [acfsl_pkg::CW-1:0]     w_wdata;
    logic [acfsl_pkg::GLOB_BITS-1:0] w_g49;
    logic [acfsl_pkg::CH_BITS-1:0]   w_c12;
    logic [15:0]                  w_mask16;
    logic                         w_chip_bad;
    logic                         w_ch_bad;
    logic                         w_gf_bad;
    logic                         w_cf_bad;

    assign w_g      = r_glob[r_item.chip[CHIP_W-1:0]];
    assign w_gm     = acfsl_pkg::g_mask(r_item.fld_idx);
    assign w_goff   = acfsl_pkg::g_off(r_item.fld_idx);
    assign w_cm     = acfsl_pkg::c_mask(r_item.fld_idx[1:0]);
    assign w_coff   = acfsl_pkg::c_off(r_item.fld_idx[1:0]);
    assign w_cv     = (r_item.fld_idx == 4'd0) ? 32'(r_item.value == 32'd0) : r_item.value;
    assign w_merged = (r_rdata & ~w_cm) | (acfsl_pkg::CW'(w_cv << w_coff) & w_cm);
    assign w_wdata  = i_cmd.clr ? '0 : w_merged;
    assign w_mask16 = 16'(r_item.chip_set);

    assign w_chip_bad = {1'b0, r_item.chip} >= 5'(NUM_CHIPS);
    assign w_ch_bad   = r_item.channel >= 12'(NUM_CH);
    assign w_gf_bad   = r_item.fld_idx >= 4'(acfsl_pkg::G_FIELDS);
    assign w_cf_bad   = r_item.fld_idx >= 4'(acfsl_pkg::C_FIELDS);

    always_comb begin
        o_sts.op     = r_item.operation;
        o_sts.all    = r_item.channel == acfsl_pkg::ALL_CH;
        o_sts.end_up = r_addr == CH_W'(NUM_CH - 1);
        o_sts.end_dn = r_addr[4:0] == 5'd0;
        case (r_item.operation)
            acfsl_pkg::OP_SET_G: o_sts.fail = w_gf_bad;
            acfsl_pkg::OP_SET_C: o_sts.fail = w_cf_bad || (w_ch_bad && !o_sts.all);
            acfsl_pkg::OP_GET_G: o_sts.fail = w_chip_bad || w_gf_bad;
            acfsl_pkg::OP_GET_C: o_sts.fail = w_ch_bad || w_cf_bad;
            acfsl_pkg::OP_LOAD:  o_sts.fail = w_chip_bad;
            default:             o_sts.fail = 1'b1;
        endcase
    end

    assign w_g49 = {w_g[11], 1'b0, w_g[28], w_g[4], 1'b0, w_g[2], w_g[3],
                    w_g[22], w_g[23], w_g[24], w_g[25], w_g[26], 2'b00, w_g[9], w_g[10],
                    w_g[8], w_g[7], 1'b0, w_g[0], w_g[1], w_g[5], 2'b00, w_g[6], w_g[27],
                    3'b000, 10'b0,
                    w_g[12], w_g[13], w_g[14], w_g[15], w_g[16],
                    w_g[17], w_g[18], w_g[19], w_g[20], w_g[21]};
    assign w_c12 = {r_rdata[1], r_rdata[0], 2'b00, r_rdata[2], r_rdata[3], r_rdata[4],
                    1'b0, r_rdata[5], r_rdata[6], r_rdata[7], r_rdata[8]};

    always_comb begin
        n_addr = r_addr;
        if (i_cmd.addr_zero) begin
            n_addr = '0;
        end else if (i_cmd.addr_chan) begin
            n_addr = r_item.channel[CH_W-1:0];
        end else if (i_cmd.addr_top) begin
            n_addr = CH_W'({r_item.chip, 5'h1f});
        end else if (i_cmd.addr_inc) begin
            n_addr = r_addr + 1'b1;
        end else if (i_cmd.addr_dec) begin
            n_addr = r_addr - 1'b1;
        end
    end

    always_comb begin
        n_stream = r_stream;
        if (i_cmd.pack_init) begin
            n_stream = SW'(w_g49);
        end else if (i_cmd.pack_shift) begin
            n_stream = {r_stream[SW-acfsl_pkg::CH_BITS-1:0], w_c12};
        end else if (i_cmd.pack_tail) begin
            n_stream = {r_stream[SW-acfsl_pkg::TAIL_W-1:0], {acfsl_pkg::TAIL_W{1'b0}}};
        end else if (i_cmd.word_shift) begin
            n_stream = {r_stream[SW-33:0], 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            r_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHIPS; i++) begin
                r_glob[i] <= '0;
            end
        end else if (i_cmd.glob_wr) begin
            for (int i = 0; i < NUM_CHIPS; i++) begin
                if (w_mask16[i]) begin
                    r_glob[i] <= (r_glob[i] & ~w_gm) |
                                 (acfsl_pkg::GW'(r_item.value << w_goff) & w_gm);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        r_stream <= n_stream;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.wr) begin
            mem[r_addr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_comb begin
        o_res = '{kind: 1'b1, write_target: 1'b0, data: 32'd0, ok: 1'b1, last: 1'b0};
        case (i_cmd.rsel)
            acfsl_pkg::RS_STATUS: begin
                o_res.kind = 1'b0;
                o_res.ok   = !o_sts.fail;
                o_res.last = 1'b1;
            end
            acfsl_pkg::RS_GGET: begin
                o_res.kind = 1'b0;
                o_res.data = 32'((w_g & w_gm) >> w_goff);
                o_res.last = 1'b1;
            end
            acfsl_pkg::RS_CGET: begin
                o_res.kind = 1'b0;
                o_res.data = 32'((r_rdata & w_cm) >> w_coff) ^
                             32'(r_item.fld_idx == 4'd0);
                o_res.last = 1'b1;
            end
            acfsl_pkg::RS_C4:   o_res.data = acfsl_pkg::CTRL_RST;
            acfsl_pkg::RS_C0:   o_res.data = 32'd0;
            acfsl_pkg::RS_WORD: begin
                o_res.write_target = 1'b1;
                o_res.data         = r_stream[SW-1 -: 32];
            end
            acfsl_pkg::RS_C2:   o_res.data = acfsl_pkg::CTRL_SHF;
            acfsl_pkg::RS_CSEL: o_res.data = 32'(acfsl_pkg::CTRL_SEL << r_item.chip);
            acfsl_pkg::RS_END:  o_res.last = 1'b1;
            default:            o_res.last = 1'b1;
        endcase
    end

endmodule

/* hdl/acfsl_ctrl.sv */
`include "assert_macros.svh"

module acfsl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_free,
    input  acfsl_pkg::t_sts  i_sts,
    output logic             o_in_ready,
    output acfsl_pkg::t_cmd  o_cmd
);
    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00_0000_0000_0001,
        S_IDLE   = 14'b00_0000_0000_0010,
        S_DECODE = 14'b00_0000_0000_0100,
        S_RD     = 14'b00_0000_0000_1000,
        S_WAIT   = 14'b00_0000_0001_0000,
        S_TAIL   = 14'b00_0000_0010_0000,
        S_RESP   = 14'b00_0000_0100_0000,
        S_E4     = 14'b00_0000_1000_0000,
        S_E0     = 14'b00_0001_0000_0000,
        S_ED     = 14'b00_0010_0000_0000,
        S_E2     = 14'b00_0100_0000_0000,
        S_EZ     = 14'b00_1000_0000_0000,
        S_ES     = 14'b01_0000_0000_0000,
        S_EL     = 14'b10_0000_0000_0000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_wcnt;
    logic [3:0] n_wcnt;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        n_wcnt  = r_wcnt;
        o_cmd   = '0;
        o_cmd.rsel = acfsl_pkg::RS_STATUS;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr      = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_sts.end_up) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.latch = i_accept;
                if (i_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                if (!i_sts.fail) begin
                    case (i_sts.op)
                        acfsl_pkg::OP_SET_G: o_cmd.glob_wr = 1'b1;
                        acfsl_pkg::OP_SET_C: begin
                            o_cmd.addr_zero = i_sts.all;
                            o_cmd.addr_chan = !i_sts.all;
                            n_state         = S_RD;
                        end
                        acfsl_pkg::OP_GET_C: begin
                            o_cmd.addr_chan = 1'b1;
                            n_state         = S_RD;
                        end
                        acfsl_pkg::OP_LOAD: begin
                            o_cmd.addr_top  = 1'b1;
                            o_cmd.pack_init = 1'b1;
                            n_state         = S_RD;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_RESP;
                case (i_sts.op)
                    acfsl_pkg::OP_SET_C: begin
                        o_cmd.wr = 1'b1;
                        if (i_sts.all && !i_sts.end_up) begin
                            o_cmd.addr_inc = 1'b1;
                            n_state        = S_RD;
                        end
                    end
                    acfsl_pkg::OP_LOAD: begin
                        o_cmd.pack_shift = 1'b1;
                        if (i_sts.end_dn) begin
                            n_state = S_TAIL;
                        end else begin
                            o_cmd.addr_dec = 1'b1;
                            n_state        = S_RD;
                        end
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_TAIL: begin
                o_cmd.pack_tail = 1'b1;
                n_wcnt          = '0;
                n_state         = S_E4;
            end
            S_RESP: begin
                if (i_sts.fail) begin
                    o_cmd.rsel = acfsl_pkg::RS_STATUS;
                end else if (i_sts.op == acfsl_pkg::OP_GET_G) begin
                    o_cmd.rsel = acfsl_pkg::RS_GGET;
                end else if (i_sts.op == acfsl_pkg::OP_GET_C) begin
                    o_cmd.rsel = acfsl_pkg::RS_CGET;
                end
                o_cmd.emit = i_free;
                if (i_free) begin
                    n_state = S_IDLE;
                end
            end
            S_E4: begin
                o_cmd.rsel = acfsl_pkg::RS_C4;
                o_cmd.emit = i_free;
                if (i_free) begin
                    n_state = S_E0;
                end
            end
            S_E0: begin
                o_cmd.rsel = acfsl_pkg::RS_C0;
                o_cmd.emit = i_free;
                if (i_free) begin
                    n_state = S_ED;
                end
            end
            S_ED: begin
                o_cmd.rsel       = acfsl_pkg::RS_WORD;
                o_cmd.emit       = i_free;
                o_cmd.word_shift = i_free;
                if (i_free) begin
                    n_state = S_E2;
                end
            end
            S_E2: begin
                o_cmd.rsel = acfsl_pkg::RS_C2;
                o_cmd.emit = i_free;
                if (i_free) begin
                    n_state = S_EZ;
                end
            end
            S_EZ: begin
                o_cmd.rsel = acfsl_pkg::RS_C0;
                o_cmd.emit = i_free;
                if (i_free) begin
                    if (r_wcnt == acfsl_pkg::LAST_WORD) begin
                        n_state = S_ES;
                    end else begin
                        n_wcnt  = r_wcnt + 1'b1;
                        n_state = S_ED;
                    end
                end
            end
            S_ES: begin
                o_cmd.rsel = acfsl_pkg::RS_CSEL;
                o_cmd.emit = i_free;
                if (i_free) begin
                    n_state = S_EL;
                end
            end
            S_EL: begin
                o_cmd.rsel = acfsl_pkg::RS_END;
                o_cmd.emit = i_free;
                if (i_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_wcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_wcnt  <= n_wcnt;
        end
    end

    `ACFSL_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_free)
    `ACFSL_NXT(a_accept_decode, i_clk, i_rst_n, i_accept && o_in_ready, r_state == S_DECODE)
    `ACFSL_NXT(a_load_done, i_clk, i_rst_n, r_state == S_EL && i_free, r_state == S_IDLE)
    `ACFSL_IMP(a_no_item_mid_load, i_clk, i_rst_n, r_state != S_IDLE, !o_cmd.latch)

endmodule

/* hdl/asic_config_field_store_and_loader_unit.sv */
// Field store and stream loader: one item at a time. After reset the whole
// channel store is cleared before the first item is taken. A set of all
// channels reads and rewrites each channel in turn; a load reads the chip's
// 32 channels in turn through the single memory port, then sends 46 result
// transfers, one a cycle while the output is free. A result waits in an
// output register until taken.
module asic_config_field_store_and_loader_unit #(
    parameter int NUM_CHIPS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acfsl_in_if.sink  i_item,
    acfsl_out_if.source o_res
);
    acfsl_pkg::t_item w_item;
    acfsl_pkg::t_cmd  w_cmd;
    acfsl_pkg::t_sts  w_sts;
    acfsl_pkg::t_res  w_res;
    acfsl_pkg::t_res  r_res;
    logic             r_ov;
    logic             w_free;
    logic             w_in_ready;

    assign w_item = '{operation: i_item.operation, chip_set: i_item.chip_set,
                      chip: i_item.chip, channel: i_item.channel,
                      fld_idx: i_item.fld_idx, value: i_item.value};
    assign w_free       = !r_ov || o_res.ready;
    assign i_item.ready = w_in_ready;

    acfsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (i_item.valid && w_in_ready),
        .i_free     (w_free),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    acfsl_datapath #(.NUM_CHIPS(NUM_CHIPS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.kind         = r_res.kind;
    assign o_res.write_target = r_res.write_target;
    assign o_res.data         = r_res.data;
    assign o_res.ok           = r_res.ok;
    assign o_res.last         = r_res.last;

endmodule
